// ===== design/gplc_pkg.sv =====
// shared types, codes and helpers for the gated piecewise linear curve
`timescale 1ns / 1ps

package gplc_pkg;

   // curve storage
   localparam int MAX_POINTS = 8;
   localparam int PT_IDX_W   = 3;
   localparam int CNT_W      = 4;
   localparam int PT_WORD_W  = 32;

   // operation codes
   localparam logic OP_EVAL  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // gate comparison codes
   localparam logic SW_PASS_EQ = 1'b0;
   localparam logic SW_PASS_NE = 1'b1;

   // register indexes
   localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
   localparam logic [1:0] REG_SWITCH_ENABLE = 2'd1;
   localparam logic [1:0] REG_SWITCH_MATCH  = 2'd2;
   localparam logic [1:0] REG_SWITCH_OP     = 2'd3;

   // result source select
   localparam logic [1:0] RES_PASS   = 2'd0;
   localparam logic [1:0] RES_CUR    = 2'd1;
   localparam logic [1:0] RES_INTERP = 2'd2;

   typedef struct packed {
      logic                load;
      logic                mem_write;
      logic                save_prev;
      logic                seg_init;
      logic                div_step;
      logic                mul;
      logic                set_res;
      logic [1:0]          res_sel;
      logic [PT_IDX_W-1:0] rd_addr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic below;       // value below the point just read
      logic above_prev;  // value at or above the previous point
   } dp_status_type;

   // clamp an 18-bit signed value to 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== design/gplc_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module gplc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gplc_dpath.sv =====
// datapath: point store, segment compare, fraction divider, interpolation
`timescale 1ns / 1ps

module gplc_dpath import gplc_pkg::*; (
   input  logic                 clock,
   input  ctrl_cmd_type         cmd,
   input  logic signed [15:0]   req_control_value,
   input  logic [15:0]          req_current_switch,
   input  logic [2:0]           req_point_index,
   input  logic signed [15:0]   req_point_x,
   input  logic signed [15:0]   req_point_y,
   input  logic                 switch_enable,
   input  logic [15:0]          switch_match,
   input  logic                 switch_op,
   output dp_status_type        status,
   output logic signed [15:0]   mapped_value
);

   logic [PT_WORD_W-1:0] rd_word;
   logic signed [15:0]   cur_x;
   logic signed [15:0]   cur_y;

   logic signed [15:0] value_ff, value_in;
   logic               gate_ff, gate_in;
   logic signed [15:0] prev_x_ff, prev_x_in;
   logic signed [15:0] prev_y_ff, prev_y_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        den_ff, den_in;
   logic [15:0]        quot_ff, quot_in;
   logic signed [16:0] dy_ff, dy_in;
   logic signed [33:0] prod_ff, prod_in;
   logic signed [15:0] result_ff, result_in;

   logic               gate_live;
   logic               sw_eq;
   logic [16:0]        rem2;
   logic [17:0]        rem_diff;
   logic signed [16:0] num_wide;
   logic signed [16:0] den_wide;
   logic signed [17:0] interp_sum;
   logic signed [15:0] res_val;
   logic               res_gate;

   gplc_ram #(
      .WIDTH (PT_WORD_W),
      .DEPTH (MAX_POINTS)
   ) u_points (
      .clock   (clock),
      .wr_en   (cmd.mem_write),
      .wr_addr (req_point_index),
      .wr_data ({req_point_x, req_point_y}),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_word)
   );

   assign cur_x = rd_word[31:16];
   assign cur_y = rd_word[15:0];

   assign status.below      = (value_ff < cur_x);
   assign status.above_prev = (value_ff >= prev_x_ff);

   // switch gate
   assign sw_eq     = (req_current_switch == switch_match);
   assign gate_live = !switch_enable || ((switch_op == SW_PASS_NE) ? !sw_eq : sw_eq);

   // one restoring divide step
   assign rem2     = {rem_ff, 1'b0};
   assign rem_diff = {1'b0, rem2} - {2'b00, den_ff};

   assign num_wide   = 17'(value_ff) - 17'(prev_x_ff);
   assign den_wide   = 17'(cur_x) - 17'(prev_x_ff);
   assign interp_sum = 18'(prev_y_ff) + 18'($signed(prod_ff[32:16]));

   always_comb begin
      res_val  = cur_y;
      res_gate = gate_ff;
      case (cmd.res_sel)
         RES_PASS: begin
            res_val  = req_control_value;
            res_gate = gate_live;
         end
         RES_CUR: begin
            res_val = cur_y;
         end
         RES_INTERP: begin
            res_val = sat16(interp_sum);
         end
         default: begin
            res_val = cur_y;
         end
      endcase
   end

   always_comb begin
      value_in  = value_ff;
      gate_in   = gate_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;
      dy_in     = dy_ff;
      prod_in   = prod_ff;
      result_in = result_ff;
      if (cmd.load) begin
         value_in = req_control_value;
         gate_in  = gate_live;
      end
      if (cmd.save_prev) begin
         prev_x_in = cur_x;
         prev_y_in = cur_y;
      end
      if (cmd.seg_init) begin
         rem_in  = num_wide[15:0];
         den_in  = den_wide[15:0];
         dy_in   = 17'(cur_y) - 17'(prev_y_ff);
         quot_in = '0;
      end
      if (cmd.div_step) begin
         if (!rem_diff[17]) begin
            rem_in  = rem_diff[15:0];
            quot_in = {quot_ff[14:0], 1'b1};
         end else begin
            rem_in  = rem2[15:0];
            quot_in = {quot_ff[14:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         prod_in = 34'(dy_ff * $signed({1'b0, quot_ff}));
      end
      if (cmd.set_res) begin
         result_in = res_gate ? res_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      gate_ff   <= gate_in;
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quot_ff   <= quot_in;
      dy_ff     <= dy_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

   assign mapped_value = result_ff;

endmodule

// ===== design/gplc_ctrl.sv =====
// controller: segment scan, divide sequencing and result strobe
`timescale 1ns / 1ps

module gplc_ctrl import gplc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_operation,
   input  logic [3:0]    point_count,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [PT_IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]    npts_ff, npts_in;
   logic [3:0]          step_ff, step_in;
   logic                valid_ff, valid_in;

   logic [CNT_W-1:0]    npts_clip;
   logic                is_last;
   logic                accept;

   assign npts_clip = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
   assign is_last   = ({1'b0, idx_ff} == (npts_ff - 1'b1));
   assign accept    = start && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      npts_in  = npts_ff;
      step_in  = step_ff;
      valid_in = 1'b0;
      cmd      = '0;
      cmd.res_sel = RES_CUR;
      cmd.rd_addr = idx_ff + 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            cmd.rd_addr = '0;
            if (accept && (req_operation == OP_WRITE)) begin
               cmd.mem_write = 1'b1;
            end else if (accept) begin
               cmd.load = 1'b1;
               npts_in  = npts_clip;
               idx_in   = '0;
               if (npts_clip == '0) begin
                  cmd.set_res = 1'b1;
                  cmd.res_sel = RES_PASS;
                  valid_in    = 1'b1;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (idx_ff == '0) begin
               if (status.below || is_last) begin
                  cmd.set_res = 1'b1;
                  valid_in    = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.save_prev = 1'b1;
                  idx_in        = idx_ff + 1'b1;
               end
            end else if (status.above_prev && status.below) begin
               cmd.seg_init = 1'b1;
               step_in      = '0;
               state_in     = S_DIV;
            end else if (is_last) begin
               cmd.set_res = 1'b1;
               valid_in    = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.save_prev = 1'b1;
               idx_in        = idx_ff + 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == 4'hf) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_INTERP;
            valid_in    = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         npts_ff  <= '0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         npts_ff  <= npts_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ===== design/gated_piecewise_linear_curve.sv =====
// top level: csr block, controller and datapath of the gated curve
`timescale 1ns / 1ps
// a write word gives no result; busy stays low
// an evaluate word scans one breakpoint per cycle, then runs a restoring
// divide for the segment fraction and a multiply step
// results: pass-through, clamp at a point, or interpolation between points
// one evaluate word at a time; start is taken only while idle
// synchronous reset clears control and csrs; point store is undefined until written

module gated_piecewise_linear_curve import gplc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [15:0] req_control_value,
   input  logic [15:0]        req_current_switch,
   input  logic [2:0]         req_point_index,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   // result channel
   output logic               rsp_valid,
   output logic signed [15:0] rsp_mapped_value,
   // csr port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // csr storage
   logic [3:0]  point_count_ff, point_count_in;
   logic        switch_enable_ff, switch_enable_in;
   logic [15:0] switch_match_ff, switch_match_in;
   logic        switch_op_ff, switch_op_in;

   logic [1:0]  csr_index;
   logic        csr_write;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      point_count_in   = point_count_ff;
      switch_enable_in = switch_enable_ff;
      switch_match_in  = switch_match_ff;
      switch_op_in     = switch_op_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_POINT_COUNT:   point_count_in   = pwdata[3:0];
            REG_SWITCH_ENABLE: switch_enable_in = pwdata[0];
            REG_SWITCH_MATCH:  switch_match_in  = pwdata[15:0];
            REG_SWITCH_OP:     switch_op_in     = pwdata[0];
            default:           point_count_in   = point_count_ff;
         endcase
      end
   end

   // register read mux
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_POINT_COUNT:   prdata = {28'd0, point_count_ff};
         REG_SWITCH_ENABLE: prdata = {31'd0, switch_enable_ff};
         REG_SWITCH_MATCH:  prdata = {16'd0, switch_match_ff};
         REG_SWITCH_OP:     prdata = {31'd0, switch_op_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff   <= '0;
         switch_enable_ff <= 1'b0;
         switch_match_ff  <= '0;
         switch_op_ff     <= SW_PASS_EQ;
      end else begin
         point_count_ff   <= point_count_in;
         switch_enable_ff <= switch_enable_in;
         switch_match_ff  <= switch_match_in;
         switch_op_ff     <= switch_op_in;
      end
   end

   // sequencer: scan, divide, multiply, strobe
   gplc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .point_count   (point_count_ff),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   // point store and arithmetic
   gplc_dpath u_dpath (
      .clock              (clock),
      .cmd                (cmd),
      .req_control_value  (req_control_value),
      .req_current_switch (req_current_switch),
      .req_point_index    (req_point_index),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .switch_enable      (switch_enable_ff),
      .switch_match       (switch_match_ff),
      .switch_op          (switch_op_ff),
      .status             (status),
      .mapped_value       (rsp_mapped_value)
   );

   // busy only ever starts from an accepted evaluate word
   a_busy_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && (req_operation == OP_EVAL)))
      else $error("busy rose without an evaluate word");

   // a write word never produces a result strobe
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_WRITE)) |=> !rsp_valid)
      else $error("result strobe after a write word");

   // every strobe follows either work in progress or a pass-through evaluate
   a_valid_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start && (req_operation == OP_EVAL))))
      else $error("result strobe without an evaluate word");

   // no memory write while a scan is in progress
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> !busy)
      else $error("point store written while busy");

endmodule
